@@ sv/lfcq_pkg.sv @@
// ----------------------------------------------------------------------------
// lfcq_pkg
// Shared types and codes for the latest-frame coalescing queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lfcq_pkg;

	// operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_STORED    = 3'd0;
	localparam logic [2:0] STAT_OVERWROTE = 3'd1;
	localparam logic [2:0] STAT_REJECTED  = 3'd2;
	localparam logic [2:0] STAT_POPPED    = 3'd3;
	localparam logic [2:0] STAT_EMPTY     = 3'd4;
	localparam logic [2:0] STAT_STOPPED   = 3'd5;
	localparam logic [2:0] STAT_STOP_DONE = 3'd6;

	// source count register
	localparam int unsigned CNT_W       = 5;
	localparam logic [CNT_W-1:0] CNT_RESET = 5'd1;

	// frame descriptor held per slot
	typedef struct packed {
		logic [31:0] frame_number;
		logic [63:0] capture_time;
		logic [23:0] byte_count;
		logic [31:0] payload_handle;
	} frame_t;

	localparam int unsigned FRAME_W = $bits(frame_t);

	// id queue control word
	typedef struct packed {
		logic push;
		logic pop;
	} idq_ctl_t;

endpackage

`default_nettype wire

@@ sv/lfcq_ram.sv @@
// ----------------------------------------------------------------------------
// lfcq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                           wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/lfcq_idq.sv @@
// ----------------------------------------------------------------------------
// lfcq_idq
// Ring of pending source ids. Head entry is read every cycle through a registered
// read, so the oldest id is available in the cycle after the head pointer settles.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcq_idq #(
	parameter int unsigned DEPTH = 16
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  lfcq_pkg::idq_ctl_t                         ctl,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] push_id,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] head_id,
	output logic                                       empty
);

	import lfcq_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [FW-1:0] fill_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end else if (ctl.pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign empty = (fill_q == '0);

	// id storage
	lfcq_ram #(
		.WIDTH (IW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (tail_q),
		.wdata (push_id),
		.raddr (head_q),
		.rdata (head_id)
	);

	// each id is queued at most once, so the ring never overflows
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("id queue fill above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> fill_q != '0)
		else $error("id queue popped while empty");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("id queue push and pop together");

endmodule

`default_nettype wire

@@ sv/latest_frame_coalescing_queue_top.sv @@
// ----------------------------------------------------------------------------
// latest_frame_coalescing_queue_top
// Keeps the newest frame descriptor per camera source and a queue of sources
// with a pending frame; push coalesces, pop returns the oldest source.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it. Push, stop and a pop that finds the queue empty or stopped go through
// a registered read of the slot word and queue head, then an update step; a pop
// that returns a frame adds a further read step, since the slot is read at the id
// that comes out of the queue memory. done rises in the cycle in which busy falls,
// and a new command may start in that same cycle.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module latest_frame_coalescing_queue_top #(
	parameter int unsigned MAX_SOURCES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// command
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  operation,
	input  wire  [15:0] cam_id,
	input  wire  [31:0] frame_number,
	input  wire  [63:0] capture_time,
	input  wire  [23:0] byte_count,
	input  wire  [31:0] payload_handle,
	// result
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  out_source,
	output logic [31:0] out_frame_number,
	output logic [63:0] out_capture_time,
	output logic [23:0] out_byte_count,
	output logic [31:0] out_payload_handle,
	output logic [31:0] slot_drops,
	output logic [63:0] total_drops,
	// configuration
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [4:0]  cfg_data
);

	import lfcq_pkg::*;

	localparam int unsigned IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam logic [15:0] MAX_ID = 16'(MAX_SOURCES);
	// slot word: frame descriptor over the drop count
	localparam int unsigned SLOT_W = FRAME_W + 32;

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       src_cnt_q;
	logic                   stopped_q;
	logic [63:0]            total_q;
	logic [MAX_SOURCES-1:0] pend_q;
	logic [MAX_SOURCES-1:0] dvld_q;

	// command capture
	logic [1:0]   op_q;
	logic [15:0]  id_q;
	frame_t       frame_q;

	// memory access
	logic [IW-1:0] raddr;
	logic [IW-1:0] raddr_q;
	logic [IW-1:0] head_id;
	logic          q_empty;
	idq_ctl_t      idq_ctl;
	frame_t        slot_rd;
	logic [SLOT_W-1:0]  slot_word;
	logic [FRAME_W-1:0] slot_rdata;
	logic [31:0]   drop_rdata;
	logic [31:0]   drop_cur;
	logic          slot_we;
	logic [31:0]   drop_new;

	// result
	logic        res_vld;
	logic [2:0]  res_status;
	logic [3:0]  res_source;
	frame_t      res_frame;
	logic [31:0] res_drops;
	logic [63:0] total_nxt;
	logic [15:0] active;
	logic        accept;
	logic [IW-1:0] idx;
	logic [15:0] src_wide;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign idx       = id_q[IW-1:0];

	// active source count, clipped to the slot count
	assign active = ({11'd0, src_cnt_q} > MAX_ID) ? MAX_ID : {11'd0, src_cnt_q};

	// slot read address: pushed id at accept, queue head for a pop
	assign raddr = (state_q == S_EXEC) ? head_id : cam_id[IW-1:0];

	assign slot_rdata = slot_word[SLOT_W-1:32];
	assign drop_rdata = slot_word[31:0];
	assign slot_rd    = frame_t'(slot_rdata);
	assign drop_cur   = dvld_q[raddr_q] ? drop_rdata : 32'd0;

	// execute step
	always_comb begin
		res_vld    = 1'b0;
		res_status = STAT_REJECTED;
		res_source = 4'd0;
		res_frame  = '0;
		res_drops  = 32'd0;
		total_nxt  = total_q;
		idq_ctl    = '0;
		slot_we    = 1'b0;
		drop_new   = drop_cur;
		src_wide   = 16'd0;
		unique case (state_q)
			S_EXEC: begin
				unique case (op_q)
					OP_PUSH: begin
						res_vld = 1'b1;
						if (id_q < active) begin
							slot_we    = 1'b1;
							src_wide   = 16'(idx);
							res_source = src_wide[3:0];
							if (pend_q[idx]) begin
								drop_new   = (drop_cur == '1) ? drop_cur : drop_cur + 32'd1;
								total_nxt  = (total_q == '1) ? total_q : total_q + 64'd1;
								res_status = STAT_OVERWROTE;
							end else begin
								idq_ctl.push = 1'b1;
								res_status   = STAT_STORED;
							end
							res_drops = drop_new;
						end
					end
					OP_POP: begin
						if (stopped_q) begin
							res_vld    = 1'b1;
							res_status = STAT_STOPPED;
						end else if (q_empty) begin
							res_vld    = 1'b1;
							res_status = STAT_EMPTY;
						end else begin
							idq_ctl.pop = 1'b1;
						end
					end
					OP_STOP: begin
						res_vld    = 1'b1;
						res_status = STAT_STOP_DONE;
					end
					default: begin
						res_vld    = 1'b1;
						res_status = STAT_REJECTED;
					end
				endcase
			end
			S_POP: begin
				res_vld    = 1'b1;
				res_status = STAT_POPPED;
				src_wide   = 16'(raddr_q);
				res_source = src_wide[3:0];
				res_frame  = slot_rd;
				res_drops  = drop_cur;
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			src_cnt_q <= CNT_RESET;
			stopped_q <= 1'b0;
			total_q   <= 64'd0;
			pend_q    <= '0;
			dvld_q    <= '0;
			done      <= 1'b0;
		end else begin
			done    <= res_vld;
			total_q <= total_nxt;
			if (cfg_valid && cfg_ready) begin
				src_cnt_q <= cfg_data;
			end
			// drop count in the slot word is valid once the slot is written
			if (slot_we) begin
				dvld_q[idx] <= 1'b1;
			end
			if (idq_ctl.push) begin
				pend_q[idx] <= 1'b1;
			end
			if (idq_ctl.pop) begin
				pend_q[head_id] <= 1'b0;
			end
			if (state_q == S_EXEC && op_q == OP_STOP) begin
				stopped_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= idq_ctl.pop ? S_POP : S_IDLE;
				end
				S_POP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command and result words
	always_ff @(posedge clk) begin
		raddr_q <= raddr;
		if (accept) begin
			op_q                   <= operation;
			id_q                   <= cam_id;
			frame_q.frame_number   <= frame_number;
			frame_q.capture_time   <= capture_time;
			frame_q.byte_count     <= byte_count;
			frame_q.payload_handle <= payload_handle;
		end
		if (res_vld) begin
			status             <= res_status;
			out_source         <= res_source;
			out_frame_number   <= res_frame.frame_number;
			out_capture_time   <= res_frame.capture_time;
			out_byte_count     <= res_frame.byte_count;
			out_payload_handle <= res_frame.payload_handle;
			slot_drops         <= res_drops;
			total_drops        <= total_nxt;
		end
	end

	// slot descriptors and per-slot drop counts
	lfcq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_SOURCES)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (idx),
		.wdata ({frame_q, drop_new}),
		.raddr (raddr),
		.rdata (slot_word)
	);

	// queue of pending source ids
	lfcq_idq #(
		.DEPTH (MAX_SOURCES)
	) u_idq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (idq_ctl),
		.push_id (idx),
		.head_id (head_id),
		.empty   (q_empty)
	);

	// a result only follows an execute or pop-read step
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_EXEC || $past(state_q) == S_POP))
		else $error("result without a command in flight");

	// pending slots and queued ids agree
	a_pend_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == '0) == q_empty)
		else $error("pending marks disagree with id queue");

	// a popped frame always comes from a pending slot
	a_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		idq_ctl.pop |-> pend_q[head_id])
		else $error("queued id without pending mark");

	// total drop count never goes down
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |=> total_q >= $past(total_q))
		else $error("total drop count decreased");

endmodule

`default_nettype wire

@@ tb/sv/lfcq_frame_checker.sv @@
// ----------------------------------------------------------------------------
// lfcq_frame_checker
// Watches the command, result and configuration channels of the coalescing
// queue, keeps its own copy of the slots and the source queue, predicts one
// result per accepted command word and compares every result field by field.
// ----------------------------------------------------------------------------
module lfcq_frame_checker #(
	parameter int unsigned SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] cam_id,
	input  logic [31:0] frame_number,
	input  logic [63:0] capture_time,
	input  logic [23:0] byte_count,
	input  logic [31:0] payload_handle,
	// result
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [3:0]  out_source,
	input  logic [31:0] out_frame_number,
	input  logic [63:0] out_capture_time,
	input  logic [23:0] out_byte_count,
	input  logic [31:0] out_payload_handle,
	input  logic [31:0] slot_drops,
	input  logic [63:0] total_drops,
	// configuration
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// tallies for the testbench top
	output int          errors,
	output int          outstanding,
	output int          checked,
	output int          popped,
	output int          overwrites,
	output int          rejects
);
	import lfcq_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  src;
		frame_t      frame;
		logic [31:0] slot_drops;
		logic [63:0] total_drops;
	} outcome_t;

	// shadow copy of the queue state
	logic [CNT_W-1:0] src_limit;
	logic             pend [SLOTS];
	frame_t           desc [SLOTS];
	logic [31:0]      src_drops [SLOTS];
	logic [3:0]       id_ring [SLOTS];
	int unsigned      ring_rd;
	int unsigned      ring_wr;
	int unsigned      ring_count;
	logic [63:0]      drops_sum;
	logic             halted;

	// results still owed by the block, oldest first
	outcome_t         owed_q[$];

	// apply one command word to the shadow state and work out its result
	task automatic apply_command(input logic [1:0] op, input logic [15:0] id,
			input frame_t f, output outcome_t o);
		int unsigned act;
		logic [3:0]  s;
		o = '0;
		act = (src_limit > SLOTS) ? SLOTS : 32'(src_limit);
		case (op)
			OP_PUSH: begin
				if (id >= act) begin
					o.status = STAT_REJECTED;
				end else begin
					s = id[3:0];
					if (pend[s]) begin
						// coalesce: newest frame wins, count the drop
						if (src_drops[s] != '1)
							src_drops[s] = src_drops[s] + 32'd1;
						if (drops_sum != '1)
							drops_sum = drops_sum + 64'd1;
						o.status = STAT_OVERWROTE;
					end else begin
						pend[s] = 1'b1;
						id_ring[ring_wr] = s;
						ring_wr = (ring_wr + 1) % SLOTS;
						ring_count++;
						o.status = STAT_STORED;
					end
					desc[s] = f;
					o.src = s;
					o.slot_drops = src_drops[s];
				end
			end
			OP_POP: begin
				if (halted) begin
					o.status = STAT_STOPPED;
				end else if (ring_count == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					s = id_ring[ring_rd];
					ring_rd = (ring_rd + 1) % SLOTS;
					ring_count--;
					pend[s] = 1'b0;
					o.status = STAT_POPPED;
					o.src = s;
					o.frame = desc[s];
					o.slot_drops = src_drops[s];
				end
			end
			OP_STOP: begin
				halted = 1'b1;
				o.status = STAT_STOP_DONE;
			end
			default: begin
				o.status = STAT_REJECTED;
			end
		endcase
		o.total_drops = drops_sum;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			errors++;
		end
	endtask

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t fresh;
		frame_t   f;
		if (!arst_n) begin
			src_limit = CNT_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				pend[i] = 1'b0;
				desc[i] = '0;
				src_drops[i] = '0;
				id_ring[i] = '0;
			end
			ring_rd = 0;
			ring_wr = 0;
			ring_count = 0;
			drops_sum = '0;
			halted = 1'b0;
			owed_q.delete();
			errors = 0;
			checked = 0;
			popped = 0;
			overwrites = 0;
			rejects = 0;
		end else begin
			// result word
			if (done) begin
				if (owed_q.size() == 0) begin
					$error("result word with no command outstanding (status 0x%0h)", status);
					errors++;
				end else begin
					want = owed_q[0];
					owed_q.delete(0);
					check_field("status", 64'(want.status), 64'(status));
					check_field("out_source", 64'(want.src), 64'(out_source));
					check_field("out_frame_number", 64'(want.frame.frame_number),
						64'(out_frame_number));
					check_field("out_capture_time", want.frame.capture_time,
						out_capture_time);
					check_field("out_byte_count", 64'(want.frame.byte_count),
						64'(out_byte_count));
					check_field("out_payload_handle", 64'(want.frame.payload_handle),
						64'(out_payload_handle));
					check_field("slot_drops", 64'(want.slot_drops), 64'(slot_drops));
					check_field("total_drops", want.total_drops, total_drops);
					checked++;
					if (want.status == STAT_POPPED)
						popped++;
					if (want.status == STAT_OVERWROTE)
						overwrites++;
					if (want.status == STAT_REJECTED)
						rejects++;
				end
			end
			// configuration word
			if (cfg_valid && cfg_ready)
				src_limit = cfg_data;
			// command word
			if (start && !busy) begin
				f.frame_number = frame_number;
				f.capture_time = capture_time;
				f.byte_count = byte_count;
				f.payload_handle = payload_handle;
				apply_command(operation, cam_id, f, fresh);
				owed_q.insert(owed_q.size(), fresh);
			end
		end
		outstanding = owed_q.size();
	end

endmodule

@@ tb/sv/tb_latest_frame_coalescing_queue_top.sv @@
// ----------------------------------------------------------------------------
// tb_latest_frame_coalescing_queue_top
// Drives command and configuration words into the coalescing queue with
// random gaps; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_latest_frame_coalescing_queue_top;
	import lfcq_pkg::*;

	localparam int unsigned SLOTS        = 16;
	localparam int unsigned TARGET_ITEMS = 1550;
	// the one operation code the block does not define
	localparam logic [1:0]  OP_UNUSED    = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [15:0] cam_id;
	logic [31:0] frame_number;
	logic [63:0] capture_time;
	logic [23:0] byte_count;
	logic [31:0] payload_handle;
	logic        done;
	logic [2:0]  status;
	logic [3:0]  out_source;
	logic [31:0] out_frame_number;
	logic [63:0] out_capture_time;
	logic [23:0] out_byte_count;
	logic [31:0] out_payload_handle;
	logic [31:0] slot_drops;
	logic [63:0] total_drops;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;

	int errors;
	int outstanding;
	int checked;
	int popped;
	int overwrites;
	int rejects;

	int issued;
	int settings;
	bit burst;

	latest_frame_coalescing_queue_top #(.MAX_SOURCES(SLOTS)) dut (.*);

	lfcq_frame_checker #(.SLOTS(SLOTS)) frame_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

	// send one command word; returns at the falling edge after acceptance
	// with start still high, so a zero gap keeps it high into the next word
	task automatic issue(input logic [1:0] op, input logic [15:0] id,
			input logic [31:0] fn, input logic [63:0] ts, input logic [23:0] sz,
			input logic [31:0] hd);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		cam_id = id;
		frame_number = fn;
		capture_time = ts;
		byte_count = sz;
		payload_handle = hd;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		issued++;
	endtask

	task automatic push_frame(input logic [15:0] id);
		issue(OP_PUSH, id, $urandom, {$urandom, $urandom},
			24'($urandom_range(0, 24'hFFFFFF)), $urandom);
	endtask

	task automatic pop_frame();
		issue(OP_POP, 16'($urandom_range(0, 16'hFFFF)), $urandom, {$urandom, $urandom},
			24'($urandom_range(0, 24'hFFFFFF)), $urandom);
	endtask

	// write the source count once every result is back
	task automatic set_source_count(input logic [4:0] n);
		start = 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_data = n;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings++;
	endtask

	initial begin
		int unsigned phase;
		int unsigned act;
		int unsigned push_pct;
		int unsigned r;
		int unsigned n;
		logic [4:0]  cnt;
		logic [15:0] id;

		start = 1'b0;
		operation = OP_PUSH;
		cam_id = '0;
		frame_number = '0;
		capture_time = '0;
		byte_count = '0;
		payload_handle = '0;
		cfg_valid = 1'b0;
		cfg_data = CNT_RESET;
		arst_n = 1'b0;
		issued = 0;
		settings = 0;
		burst = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset count of one, empty pop, coalescing, field extremes
		issue(OP_POP, '0, '0, '0, '0, '0);
		issue(OP_PUSH, 16'd0, '1, '1, '1, '1);
		issue(OP_PUSH, 16'd1, '1, '1, '1, '1);
		issue(OP_PUSH, 16'd0, '0, '0, '0, '0);
		issue(OP_POP, '1, '1, '1, '1, '1);
		issue(OP_UNUSED, 16'd0, '1, '1, '1, '1);
		// zero sources: every push rejected
		set_source_count(5'd0);
		issue(OP_PUSH, 16'd0, '1, '0, '1, '0);
		// count above the slot total is clamped
		set_source_count(5'd31);
		push_frame(16'd15);
		push_frame(16'd16);
		push_frame(16'hFFFF);
		push_frame(16'd3);
		push_frame(16'd15);
		// lowered count: already queued slots still come out
		set_source_count(5'd2);
		push_frame(16'd3);
		pop_frame();
		pop_frame();
		pop_frame();

		// random phases over a spread of source counts
		phase = 0;
		while (issued < TARGET_ITEMS - 45) begin
			case (phase % 6)
				0: cnt = 5'd16;
				1: cnt = 5'd1;
				2: cnt = 5'd0;
				3: cnt = 5'd31;
				4: cnt = 5'($urandom_range(17, 30));
				default: cnt = 5'($urandom_range(2, 15));
			endcase
			set_source_count(cnt);
			act = (cnt > SLOTS) ? SLOTS : 32'(cnt);
			burst = ($urandom_range(0, 3) == 0);
			push_pct = $urandom_range(30, 80);
			n = (act == 0) ? 10 : $urandom_range(40, 120);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					issue(OP_UNUSED, 16'($urandom_range(0, 16'hFFFF)), $urandom,
						{$urandom, $urandom}, 24'($urandom_range(0, 24'hFFFFFF)), $urandom);
				end else if (r < 4) begin
					push_frame(16'($urandom_range(0, 16'hFFFF)));
				end else if (r < push_pct) begin
					if (act == 0 || $urandom_range(0, 9) == 0)
						id = 16'($urandom_range(0, SLOTS));
					else
						id = 16'($urandom_range(0, act - 1));
					push_frame(id);
				end else begin
					pop_frame();
				end
			end
			phase++;
		end

		// stop: pops report stopped, pushes still coalesce, stop repeats
		burst = 1'b0;
		set_source_count(5'd16);
		push_frame(16'd2);
		push_frame(16'd5);
		issue(OP_STOP, '0, '0, '0, '0, '0);
		pop_frame();
		push_frame(16'd2);
		push_frame(16'd7);
		issue(OP_STOP, '1, '1, '1, '1, '1);
		pop_frame();
		issue(OP_UNUSED, '0, '0, '0, '0, '0);
		repeat (36) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				push_frame(16'($urandom_range(0, SLOTS)));
			else if (r < 9)
				pop_frame();
			else
				issue(OP_STOP, 16'($urandom_range(0, 16'hFFFF)), $urandom,
					{$urandom, $urandom}, 24'($urandom_range(0, 24'hFFFFFF)), $urandom);
		end

		// drain and let any stray result word show up
		start = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Summary: %0d commands under %0d source-count settings, %0d results checked",
			issued, settings, checked);
		$display("  %0d frames popped, %0d overwrites, %0d rejects",
			popped, overwrites, rejects);
		if (errors == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
